// ===== rtl/rfrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Radio frame receive CRC check: shared package
// Types, status codes, frame phase codes and the CRC polynomial.
// ----------------------------------------------------------------------------
package rfrc_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [1:0]  status_t;
    typedef logic [1:0]  phase_t;
    typedef logic [15:0] crc_t;

    // Result status codes.
    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_EMPTY  = 2'd1;
    localparam status_t ST_CRCERR = 2'd2;
    localparam status_t ST_LENERR = 2'd3;

    // Frame phases: which byte of the frame is expected next.
    localparam phase_t PH_LEN   = 2'd0;
    localparam phase_t PH_DATA  = 2'd1;
    localparam phase_t PH_CRCLO = 2'd2;
    localparam phase_t PH_CRCHI = 2'd3;

    // CRC-16/XMODEM generator polynomial.
    localparam crc_t CRC_POLY = 16'h1021;

endpackage

// ===== rtl/rfrc_in_if.sv =====
// ----------------------------------------------------------------------------
// Radio frame receive CRC check: input channel
// Carries one received byte per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rfrc_in_if
    import rfrc_pkg::*;
();

    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

// ===== rtl/rfrc_out_if.sv =====
// ----------------------------------------------------------------------------
// Radio frame receive CRC check: result channel
// Carries one payload byte or status per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rfrc_out_if
    import rfrc_pkg::*;
();

    logic    valid;
    logic    ready;
    byte_t   payload_byte;
    status_t frame_status;
    logic    last;

    modport source (output valid, output payload_byte, output frame_status,
                    output last, input ready);
    modport sink   (input valid, input payload_byte, input frame_status,
                    input last, output ready);

endinterface

// ===== rtl/radio_frame_receive_crc_check.sv =====
// ----------------------------------------------------------------------------
// Radio frame receive CRC check
// Buffers a length-prefixed frame, checks its CRC-16/XMODEM bit-serially and
// releases the payload only when the check passes.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Fields                              Meaning
//   in_ch     sink       rx_byte[7:0]                        one received byte
//   out_ch    source     payload_byte[7:0], frame_status[1:0], last
//                                                            one result item
//
// A length or payload byte is accepted and then shifted bit-serially through
// the CRC register before the next byte is taken; the CRC low and high bytes
// are only accepted. A passing frame is released item by item, each payload
// byte passing the registered read of the payload store. Reset is asynchronous
// and active low; it returns the block to waiting for a length byte. A stalled
// result holds in the output register, and a new input item is still taken
// then unless it could itself give a result.
//
module radio_frame_receive_crc_check
    import rfrc_pkg::*;
#(
    parameter int MAX_LEN = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    rfrc_in_if.sink           in_ch,
    rfrc_out_if.source        out_ch
);

    // Count width holds a length up to MAX_LEN; address width indexes the store.
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CRC  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam logic [2:0] BIT_LAST = 3'd7;

    logic [1:0]    state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [CW-1:0] frame_length_reg, frame_length_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    crc_t          crc_reg, crc_next;
    byte_t         crc_low_reg, crc_low_next;
    byte_t         shift_reg, shift_next;
    logic [2:0]    bit_cnt_reg, bit_cnt_next;

    logic          out_valid_reg, out_valid_next;
    byte_t         payload_reg, payload_next;
    status_t       status_reg, status_next;
    logic          last_reg, last_next;

    // Payload store: written while the frame arrives, read back in order.
    byte_t         store_mem [MAX_LEN];
    byte_t         rd_data_reg;
    logic          wr_en;

    logic          in_acc;
    logic          out_free;
    logic          crc_top;
    logic [CW-1:0] count_inc;
    logic [CW-1:0] rd_inc;
    crc_t          rx_crc;

    // An item is taken whenever the block is idle, unless the byte could give
    // a result while the output register is still occupied.
    assign in_ch.ready = (state_reg == S_IDLE) &&
                         (!out_valid_reg || out_ch.ready ||
                          phase_reg == PH_DATA || phase_reg == PH_CRCLO);

    assign in_acc    = in_ch.valid && in_ch.ready;
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign crc_top   = crc_reg[15] ^ shift_reg[7];
    assign count_inc = byte_count_reg + CW'(1);
    assign rd_inc    = rd_idx_reg + CW'(1);
    assign rx_crc    = {in_ch.rx_byte, crc_low_reg};
    assign wr_en     = in_acc && (phase_reg == PH_DATA);

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.payload_byte = payload_reg;
    assign out_ch.frame_status = status_reg;
    assign out_ch.last         = last_reg;

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        frame_length_next = frame_length_reg;
        rd_idx_next       = rd_idx_reg;
        crc_next          = crc_reg;
        crc_low_next      = crc_low_reg;
        shift_next        = shift_reg;
        bit_cnt_next      = bit_cnt_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        payload_next      = payload_reg;
        status_next       = status_reg;
        last_next         = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (phase_reg)
                        PH_LEN:
                        begin
                            if (in_ch.rx_byte > 8'(MAX_LEN))
                            begin
                                // Oversized length: report and wait for a new length.
                                out_valid_next = 1'b1;
                                payload_next   = '0;
                                status_next    = ST_LENERR;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                frame_length_next = in_ch.rx_byte[CW-1:0];
                                byte_count_next   = '0;
                                crc_next          = '0;
                                shift_next        = in_ch.rx_byte;
                                bit_cnt_next      = '0;
                                state_next        = S_CRC;
                                phase_next        = (in_ch.rx_byte == 8'd0) ? PH_CRCLO
                                                                             : PH_DATA;
                            end
                        end
                        PH_DATA:
                        begin
                            byte_count_next = count_inc;
                            shift_next      = in_ch.rx_byte;
                            bit_cnt_next    = '0;
                            state_next      = S_CRC;
                            if (count_inc >= frame_length_reg)
                            begin
                                phase_next = PH_CRCLO;
                            end
                        end
                        PH_CRCLO:
                        begin
                            crc_low_next = in_ch.rx_byte;
                            phase_next   = PH_CRCHI;
                        end
                        default:
                        begin
                            phase_next      = PH_LEN;
                            byte_count_next = '0;
                            if (rx_crc != crc_reg)
                            begin
                                out_valid_next = 1'b1;
                                payload_next   = '0;
                                status_next    = ST_CRCERR;
                                last_next      = 1'b1;
                            end
                            else if (frame_length_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                payload_next   = '0;
                                status_next    = ST_EMPTY;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                rd_idx_next = '0;
                                state_next  = S_RD;
                            end
                        end
                    endcase
                end
            end
            S_CRC:
            begin
                // One message bit per cycle through the CRC register, MSB first.
                crc_next     = {crc_reg[14:0], 1'b0} ^ (crc_top ? CRC_POLY : crc_t'(0));
                shift_next   = {shift_reg[6:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == BIT_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD:
            begin
                state_next = S_OUT;
            end
            default:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    payload_next   = rd_data_reg;
                    status_next    = ST_OK;
                    last_next      = (rd_inc == frame_length_reg);
                    rd_idx_next    = rd_inc;
                    state_next     = (rd_inc == frame_length_reg) ? S_IDLE : S_RD;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_LEN;
            byte_count_reg   <= '0;
            frame_length_reg <= '0;
            rd_idx_reg       <= '0;
            crc_reg          <= '0;
            crc_low_reg      <= '0;
            bit_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            frame_length_reg <= frame_length_next;
            rd_idx_reg       <= rd_idx_next;
            crc_reg          <= crc_next;
            crc_low_reg      <= crc_low_next;
            bit_cnt_reg      <= bit_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        payload_reg <= payload_next;
        status_reg  <= status_next;
        last_reg    <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[byte_count_reg[AW-1:0]] <= in_ch.rx_byte;
        end
        rd_data_reg <= store_mem[rd_idx_reg[AW-1:0]];
    end

endmodule

// ===== rtl/rfrc_checker.sv =====
// ----------------------------------------------------------------------------
// Radio frame receive CRC check: port checker
// Watches the ports of the top level and flags results and input handshakes that break its rules.
// ----------------------------------------------------------------------------
module rfrc_checker
    import rfrc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input byte_t   payload_byte,
    input status_t frame_status,
    input logic    last
);

    // Status-only results carry a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_status != ST_OK |-> payload_byte == 8'd0)
        else $error("status result with non-zero payload byte");

    // Every status-only result closes its frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_status != ST_OK |-> last)
        else $error("status result without last");

    // No new byte is taken while a payload run is still being released.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_status == ST_OK && !last |-> !(in_valid && in_ready))
        else $error("input taken in the middle of a payload run");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(payload_byte) &&
                                    $stable(frame_status) && $stable(last))
        else $error("stalled result changed");

endmodule

bind radio_frame_receive_crc_check rfrc_checker u_rfrc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .payload_byte (out_ch.payload_byte),
    .frame_status (out_ch.frame_status),
    .last         (out_ch.last)
);

// ===== sim/tb_radio_frame_receive_crc_check.sv =====
// ----------------------------------------------------------------------------
// Testbench for the radio frame receive CRC check
// Drives length-prefixed frames through the input channel and checks every
// result item against a cycle-free model of the receiver. The model tracks the
// frame phase, buffers the payload and runs its own CRC-16/XMODEM.
// ----------------------------------------------------------------------------
module tb_radio_frame_receive_crc_check;

    import rfrc_pkg::*;

    // The largest payload that the block accepts.
    localparam int FRAME_MAX = 32;

    // Cycles with no item accepted on either channel before the run is
    // abandoned. The longest deliberate hold-off is far shorter than this.
    localparam int QUIET_LIMIT = 5000;

    // Cycles to let pass once nothing is expected any more; this covers bytes
    // that still occupy the block while their bits go through the CRC register.
    localparam int SETTLE_CYCLES = 40;

    // Length of the receiver hold-off used to fill the block up.
    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        byte_t   payload_byte;
        status_t frame_status;
        logic    last;
    } rx_result_t;

    logic clk;
    logic rst_n;

    rfrc_in_if  in_ch ();
    rfrc_out_if out_ch ();

    radio_frame_receive_crc_check #(
        .MAX_LEN (FRAME_MAX)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // ------------------------------------------------------------------------
    // Shared state of the testbench.
    // ------------------------------------------------------------------------

    // Results that the frame model has produced and the block has yet to give.
    rx_result_t awaited_results [$];
    rx_result_t oldest_result;

    // Frame model: the phase of the frame, the payload so far and the CRC.
    phase_t     model_phase;
    logic [6:0] model_count;
    logic [6:0] model_length;
    crc_t       model_crc;
    byte_t      model_crc_low;
    byte_t      model_payload [FRAME_MAX];

    // Payload of the next frame to be sent.
    byte_t      frame_body [$];

    // Idling controls, read by the sender task and the receiver process.
    int         send_idle_pct;
    int         recv_stall_pct;
    int         hold_left;

    int         items_sent;
    int         mismatch_count;
    int         quiet_cycles;

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // CRC-16/XMODEM, one byte at a time, most significant bit first. The byte
    // is shifted in beside the register rather than xored in up front, which
    // gives the same remainder as the usual table form.
    // ------------------------------------------------------------------------
    function automatic crc_t crc16_xmodem_update(input crc_t crc, input byte_t data);
        crc_t reg_val;
        crc_t shifted_data;
        logic feedback;
        reg_val      = crc;
        shifted_data = {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            feedback     = reg_val[15] ^ shifted_data[15];
            reg_val      = reg_val << 1;
            if (feedback)
            begin
                reg_val = reg_val ^ CRC_POLY;
            end
            shifted_data = shifted_data << 1;
        end
        return reg_val;
    endfunction

    // ------------------------------------------------------------------------
    // Frame model. Called once for each byte that the block accepts, in the
    // order of acceptance; it queues whatever results that byte causes.
    // ------------------------------------------------------------------------
    task automatic model_receive_byte(input byte_t data);
        crc_t received_crc;
        case (model_phase)
            PH_LEN:
            begin
                if (data > FRAME_MAX)
                begin
                    // An oversized length is refused at once and the next
                    // byte is read as a fresh length.
                    awaited_results.push_back('{8'h00, ST_LENERR, 1'b1});
                end
                else
                begin
                    model_length = data[6:0];
                    model_count  = '0;
                    model_crc    = crc16_xmodem_update(16'h0000, data);
                    model_phase  = (data == 8'h00) ? PH_CRCLO : PH_DATA;
                end
            end
            PH_DATA:
            begin
                model_payload[model_count] = data;
                model_crc   = crc16_xmodem_update(model_crc, data);
                model_count = model_count + 7'd1;
                if (model_count >= model_length)
                begin
                    model_phase = PH_CRCLO;
                end
            end
            PH_CRCLO:
            begin
                model_crc_low = data;
                model_phase   = PH_CRCHI;
            end
            default:
            begin
                // The CRC arrives low byte first.
                received_crc = {data, model_crc_low};
                if (received_crc != model_crc)
                begin
                    awaited_results.push_back('{8'h00, ST_CRCERR, 1'b1});
                end
                else if (model_length == 7'd0)
                begin
                    awaited_results.push_back('{8'h00, ST_EMPTY, 1'b1});
                end
                else
                begin
                    for (int i = 0; i < model_length; i++)
                    begin
                        awaited_results.push_back('{model_payload[i], ST_OK,
                                                    i == model_length - 1});
                    end
                end
                model_phase = PH_LEN;
                model_count = '0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Sender. Called just after a rising edge; returns at the rising edge at
    // which the item is taken. This task lowers the valid line only when a gap
    // is wanted, so back-to-back items keep it high across the edge.
    // ------------------------------------------------------------------------
    task automatic send_item(input byte_t data);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= data;
        // The handshake is judged at the falling edge, where nothing changes.
        do
        begin
            @(negedge clk);
        end
        while (!in_ch.ready);
        @(posedge clk);
        items_sent++;
        model_receive_byte(data);
    endtask

    // Sends frame_body as one frame: its length, the payload and the CRC.
    // Either CRC byte can be spoilt by a random non-zero flip.
    task automatic send_frame(input bit spoil_low, input bit spoil_high);
        crc_t  frame_crc;
        byte_t length_byte;
        length_byte = byte_t'(frame_body.size());
        frame_crc   = crc16_xmodem_update(16'h0000, length_byte);
        send_item(length_byte);
        foreach (frame_body[i])
        begin
            frame_crc = crc16_xmodem_update(frame_crc, frame_body[i]);
            send_item(frame_body[i]);
        end
        if (spoil_low)
        begin
            frame_crc[7:0] = frame_crc[7:0] ^ byte_t'($urandom_range(255, 1));
        end
        if (spoil_high)
        begin
            frame_crc[15:8] = frame_crc[15:8] ^ byte_t'($urandom_range(255, 1));
        end
        send_item(frame_crc[7:0]);
        send_item(frame_crc[15:8]);
    endtask

    task automatic fill_random_body(input int length);
        frame_body.delete();
        repeat (length)
        begin
            frame_body.push_back(byte_t'($urandom_range(255)));
        end
    endtask

    // Lowers valid, waits for every awaited result and lets the block settle.
    task automatic wait_until_idle();
        in_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES)
        begin
            @(posedge clk);
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40)
        begin
            $display("ERROR at %0t: %s", $time, what);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver. Ready is redrawn at every rising edge; a pending hold-off
    // keeps it low until its count, hold_left, has run down to zero.
    // ------------------------------------------------------------------------
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct)
            begin
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker. A result item seen with valid and ready at the falling
    // edge is taken at the next rising edge; it is compared with the oldest
    // awaited result, field by field.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result: byte %02h status %0d last %0b",
                                          out_ch.payload_byte, out_ch.frame_status,
                                          out_ch.last));
            end
            else
            begin
                oldest_result = awaited_results.pop_front();
                if (out_ch.payload_byte !== oldest_result.payload_byte)
                begin
                    report_mismatch($sformatf("payload_byte %02h, wanted %02h",
                                              out_ch.payload_byte,
                                              oldest_result.payload_byte));
                end
                if (out_ch.frame_status !== oldest_result.frame_status)
                begin
                    report_mismatch($sformatf("frame_status %0d, wanted %0d",
                                              out_ch.frame_status,
                                              oldest_result.frame_status));
                end
                if (out_ch.last !== oldest_result.last)
                begin
                    report_mismatch($sformatf("last %0b, wanted %0b",
                                              out_ch.last, oldest_result.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog. Counts cycles in which neither channel moves an item.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Lengths just above the limit and at the top of the byte range are
    // refused with a length error, one result each, and do not open a frame.
    task automatic test_length_errors();
        send_item(byte_t'(FRAME_MAX + 1));
        send_item(8'hFF);
        wait_until_idle();
    endtask

    // A zero-length frame goes straight to the CRC bytes. With the right CRC
    // it gives the ok-empty status, with a wrong one a CRC error.
    task automatic test_empty_frames();
        frame_body.delete();
        send_frame(1'b0, 1'b0);
        send_frame(1'b0, 1'b1);
        wait_until_idle();
    endtask

    // One-byte frames carrying the extremes of the byte range. An all-zero
    // payload byte must still come out with the ok status.
    task automatic test_single_byte_frames();
        frame_body = {8'h00};
        send_frame(1'b0, 1'b0);
        frame_body = {8'hFF};
        send_frame(1'b0, 1'b0);
        wait_until_idle();
    endtask

    // A spoilt CRC byte, high or low, drops the payload and gives a single
    // CRC error in its place.
    task automatic test_crc_corruption();
        frame_body = {8'hA5, 8'h5A};
        send_frame(1'b0, 1'b1);
        frame_body = {8'h80};
        send_frame(1'b1, 1'b0);
        wait_until_idle();
    endtask

    // The receiver holds off while two good frames, the first of the largest
    // size, are offered back to back. The first result of the first frame
    // waits in the output register, the payload run halts there and the
    // input stalls on the second frame's length byte until the hold-off has
    // run out.
    task automatic test_receiver_hold_off();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = HOLD_CYCLES;
        fill_random_body(FRAME_MAX);
        send_frame(1'b0, 1'b0);
        fill_random_body(4);
        send_frame(1'b0, 1'b0);
        wait_until_idle();
    endtask

    // Mostly well-formed frames with random payloads, mostly short, and a
    // share of spoilt CRCs, oversized lengths, cut-short frames and stray
    // bytes. Cut-short frames and stray bytes knock the framing out of step
    // for a while, which the model follows byte by byte.
    task automatic test_random_traffic(input int item_goal, input int idle_pct,
                                       input int stall_pct);
        int first_item;
        int pick;
        int length;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first_item     = items_sent;
        while (items_sent - first_item < item_goal)
        begin
            pick   = $urandom_range(99);
            length = ($urandom_range(99) < 85) ? $urandom_range(8)
                                               : $urandom_range(FRAME_MAX, 9);
            if (pick < 70)
            begin
                fill_random_body(length);
                send_frame(1'b0, 1'b0);
            end
            else if (pick < 85)
            begin
                fill_random_body(length);
                pick = $urandom_range(2);
                send_frame(pick != 1, pick != 0);
            end
            else if (pick < 92)
            begin
                send_item(byte_t'($urandom_range(255, FRAME_MAX + 1)));
            end
            else if (pick < 96)
            begin
                length = $urandom_range(8, 2);
                send_item(byte_t'(length));
                repeat ($urandom_range(length - 1))
                begin
                    send_item(byte_t'($urandom_range(255)));
                end
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                begin
                    send_item(byte_t'($urandom_range(255)));
                end
            end
        end
        wait_until_idle();
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.rx_byte  <= 8'h00;
        model_phase    = PH_LEN;
        model_count    = '0;
        model_length   = '0;
        model_crc      = '0;
        model_crc_low  = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        items_sent     = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;

        repeat (9)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        test_length_errors();
        test_empty_frames();
        test_single_byte_frames();
        test_crc_corruption();
        test_receiver_hold_off();
        test_random_traffic(100, 0, 0);
        test_random_traffic(100, 54, 0);
        test_random_traffic(100, 0, 54);
        test_random_traffic(100, 20, 20);

        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
